// ----- design/sfm_pkg.sv -----
package sfm_pkg;

  localparam int SYNC_LEN      = 32;
  localparam int TRAIN_LEN     = 16;
  localparam int INTERVAL_BITS = 1024;
  localparam int PILOT_GAP     = 32;
  localparam int PILOT_LEN     = 4;

  localparam int LABEL_W = 8;
  localparam int SAMP_W  = 16;
  localparam int KIND_W  = 2;
  localparam int ORDER_W = 2;
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;
  localparam int POS_W   = 10;
  localparam int GRP_W   = 9;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int TRN_N   = (TRAIN_LEN > 0) ? TRAIN_LEN : 1;
  localparam int RUN_MAX = (SYNC_LEN > TRN_N) ?
                           ((SYNC_LEN > PILOT_LEN) ? SYNC_LEN : PILOT_LEN) :
                           ((TRN_N > PILOT_LEN) ? TRN_N : PILOT_LEN);
  localparam int CNT_W   = (RUN_MAX > 1) ? $clog2(RUN_MAX) : 1;
  localparam int TRN_IW  = (TRN_N > 1) ? $clog2(TRN_N) : 1;
  localparam int SYN_IW  = (SYNC_LEN > 1) ? $clog2(SYNC_LEN) : 1;
  localparam int PIL_IW  = (PILOT_LEN > 1) ? $clog2(PILOT_LEN) : 1;

  localparam logic [KIND_W-1:0] KIND_TRAIN = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SYNC  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DATA  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_PILOT = 2'd3;

  localparam logic [APB_AW-1:0] ADDR_ORDER = 3'd0;

  localparam logic [31:0]       SYNC_SEED   = 32'h65a39c17;
  localparam logic [SAMP_W-1:0] SYNC_AMP    = 16'd5793;
  localparam logic [63:0]       HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0]       ONE_Q30     = 64'd1 << 30;

  localparam logic [63:0] DIV_COS [11] = '{64'd1, 64'd2, 64'd12, 64'd30, 64'd56, 64'd90,
                                           64'd132, 64'd182, 64'd240, 64'd306, 64'd380};
  localparam logic [63:0] DIV_SIN [11] = '{64'd1, 64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
                                           64'd156, 64'd210, 64'd272, 64'd342, 64'd420};
  localparam logic [63:0] RADII16  [2] = '{64'd100, 64'd285};
  localparam logic [63:0] RADII_STD [8] = '{64'd100, 64'd280, 64'd460, 64'd640,
                                            64'd820, 64'd1000, 64'd1180, 64'd1360};

  localparam logic [LABEL_W-1:0] LABEL_MASK [4] = '{8'h03, 8'h0f, 8'h3f, 8'hff};
  localparam logic [POS_W-1:0]   INTERVAL_SYMS [4] = '{
    POS_W'((INTERVAL_BITS + 1) / 2), POS_W'((INTERVAL_BITS + 3) / 4),
    POS_W'((INTERVAL_BITS + 5) / 6), POS_W'((INTERVAL_BITS + 7) / 8)};

  typedef struct packed {
    logic                     train;
    logic                     sync;
    logic                     pilot;
    logic signed [SAMP_W-1:0] i_val;
    logic signed [SAMP_W-1:0] q_val;
  } run_desc_t;

  // build-time table generation

  // shift and subtract, quotient in the upper half
  function automatic logic [127:0] udivmod64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    int          i;
    quo = '0;
    rem = '0;
    for (i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return {quo, rem[63:0]};
  endfunction

  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [127:0] qr;
    qr = udivmod64(num, den);
    return qr[127:64];
  endfunction

  function automatic logic [63:0] umod64(input logic [63:0] num, input logic [63:0] den);
    logic [127:0] qr;
    qr = udivmod64(num, den);
    return qr[63:0];
  endfunction

  function automatic logic [SYNC_LEN-1:0][31:0] gen_sync();
    logic [SYNC_LEN-1:0][31:0] tab;
    logic [31:0]               st;
    logic [SAMP_W-1:0]         iv;
    logic [SAMP_W-1:0]         qv;
    int                        s;
    tab = '0;
    st  = SYNC_SEED;
    for (s = 0; s < SYNC_LEN; s++) begin
      st = st ^ (st << 13);
      st = st ^ (st >> 17);
      st = st ^ (st << 5);
      iv = st[0] ? SYNC_AMP : 16'd0 - SYNC_AMP;
      qv = st[1] ? SYNC_AMP : 16'd0 - SYNC_AMP;
      tab[s] = {iv, qv};
    end
    return tab;
  endfunction

  localparam logic [SYNC_LEN-1:0][31:0] SYNC_TAB = gen_sync();

  function automatic logic [TRN_N-1:0][31:0] gen_train();
    logic [TRN_N-1:0][31:0] tab;
    int                     t;
    int                     idx;
    tab = '0;
    for (t = 0; t < TRAIN_LEN; t++) begin
      idx = int'(umod64(64'(t * 17 + 9), 64'(SYNC_LEN)));
      tab[t] = {16'd0 - SYNC_TAB[idx][15:0], SYNC_TAB[idx][31:16]};
    end
    return tab;
  endfunction

  localparam logic [TRN_N-1:0][31:0] TRAIN_TAB = gen_train();

  function automatic logic [PILOT_LEN-1:0][31:0] gen_pilot();
    logic [PILOT_LEN-1:0][31:0] tab;
    int                         k;
    int                         idx;
    tab = '0;
    for (k = 0; k < PILOT_LEN; k++) begin
      idx = int'(umod64(64'(11 + 13 * (k % 4)), 64'(SYNC_LEN)));
      tab[k] = SYNC_TAB[idx];
    end
    return tab;
  endfunction

  localparam logic [PILOT_LEN-1:0][31:0] PILOT_TAB = gen_pilot();

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    logic [63:0] vv;
    res  = '0;
    bitv = 64'd1 << 62;
    vv   = v;
    while (bitv > vv) bitv = bitv >> 2;
    while (bitv != 64'd0) begin
      if (vv >= res + bitv) begin
        vv  = vv - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // truncating taylor series in q30, cosine or sine
  function automatic logic [63:0] series(input logic [63:0] a, input logic start);
    logic [63:0]        term;
    logic signed [63:0] sum;
    int                 k;
    term = start ? a : ONE_Q30;
    sum  = $signed(term);
    for (k = 1; k <= 10; k++) begin
      term = (term * a) >> 30;
      term = (term * a) >> 30;
      term = udiv64(term, start ? DIV_SIN[k] : DIV_COS[k]);
      if (k % 2 == 1) sum = sum - $signed(term);
      else sum = sum + $signed(term);
    end
    if (sum < 0) sum = '0;
    if (sum > $signed(ONE_Q30)) sum = $signed(ONE_Q30);
    return $unsigned(sum);
  endfunction

  function automatic logic [SAMP_W-1:0] round_comp(input logic [63:0] amp,
                                                   input logic [63:0] mag);
    logic [63:0] prod;
    prod = amp * mag + (64'd1 << 46);
    return prod[62:47];
  endfunction

  function automatic logic [63:0] ring_radius(input int unsigned o, input int unsigned r);
    return (o == 1) ? RADII16[r] : RADII_STD[r];
  endfunction

  function automatic logic [255:0][31:0] gen_rom(input int unsigned o);
    logic [255:0][31:0] tab;
    logic [63:0]        n;
    logic [63:0]        e;
    logic [63:0]        rr;
    logic [63:0]        a2;
    logic [63:0]        val;
    logic [63:0]        rem;
    logic [63:0]        amp;
    logic [63:0]        x;
    logic [63:0]        m;
    logic [63:0]        qd;
    logic [63:0]        ang;
    logic [63:0]        cv;
    logic [63:0]        sv;
    logic [SAMP_W-1:0]  ci;
    logic [SAMP_W-1:0]  si;
    logic [7:0]         g;
    int unsigned        rings;
    int unsigned        pop;
    int unsigned        cnt;
    int unsigned        r;
    int unsigned        p;
    int unsigned        b;
    tab   = '0;
    rings = 1 << o;
    n     = 64'd4 << (2 * o);
    e     = '0;
    cnt   = 0;
    for (r = 0; r < rings; r++) begin
      rr = ring_radius(o, r);
      e  = e + 64'(4 + 8 * r) * rr * rr;
    end
    for (r = 0; r < rings; r++) begin
      rr  = ring_radius(o, r);
      a2  = rr * rr * n;
      val = udiv64(a2, e);
      rem = umod64(a2, e);
      pop = 4 + 8 * r;
      for (b = 0; b < 60; b++) begin
        rem = rem << 1;
        if (rem >= e) begin
          val = (val << 1) | 64'd1;
          rem = rem - e;
        end else begin
          val = val << 1;
        end
      end
      amp = isqrt64(val);
      for (p = 0; p < pop; p++) begin
        x   = 64'(4 * (2 * p + 1));
        m   = 64'(2 * pop);
        qd  = udiv64(x, m);
        ang = udiv64(HALF_PI_Q30 * umod64(x, m), m);
        cv  = series(ang, 1'b0);
        sv  = series(ang, 1'b1);
        ci  = round_comp(amp, cv);
        si  = round_comp(amp, sv);
        g   = 8'(cnt ^ (cnt >> 1));
        case (qd[1:0])
          2'd0:    tab[g] = {ci, si};
          2'd1:    tab[g] = {16'd0 - si, ci};
          2'd2:    tab[g] = {16'd0 - ci, 16'd0 - si};
          default: tab[g] = {si, 16'd0 - ci};
        endcase
        cnt = cnt + 1;
      end
    end
    return tab;
  endfunction

  localparam logic [3:0][255:0][31:0] MAP_ROM = {gen_rom(3), gen_rom(2), gen_rom(1),
                                                 gen_rom(0)};

endpackage

// ----- design/sfm_label_if.sv -----
interface sfm_label_if import sfm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [LABEL_W-1:0] sym_label;

  modport source (output valid, output sym_label, input ready);
  modport sink   (input valid, input sym_label, output ready);
endinterface

// ----- design/sfm_symbol_if.sv -----
interface sfm_symbol_if import sfm_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [SAMP_W-1:0] i_value;
  logic signed [SAMP_W-1:0] q_value;
  logic [KIND_W-1:0]        symbol_kind;
  logic                     last_of_run;

  modport source (output valid, output i_value, output q_value, output symbol_kind,
                  output last_of_run, input ready);
  modport sink   (input valid, input i_value, input q_value, input symbol_kind,
                  input last_of_run, output ready);
endinterface

// ----- design/symbol_framer_mapper.sv -----
// channel  | dir | transaction
// in_lbl   | in  | one data label, label_bits
// out_sym  | out | one symbol, i_value q_value symbol_kind last_of_run
// apb      | in  | order_select at byte address 0
//
// one symbol leaves per cycle from the back sequencer while a run is queued and out_sym
// is not stalled; a label with no framing yields one data symbol, the first adds 16
// training symbols, each interval start 32 sync and each group end 4 pilot symbols
// the front takes a label each cycle while the two-entry run queue has room
// synchronous active-low reset clears order_select, framing state, queue and output
// a stalled output holds its symbol and the queue absorbs new labels
module symbol_framer_mapper import sfm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  sfm_label_if.sink         in_lbl,
  sfm_symbol_if.source      out_sym,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  logic [ORDER_W-1:0] order_r;
  logic [ORDER_W-1:0] order_nxt;
  logic               reg_hit;

  logic      push_valid;
  logic      push_ready;
  run_desc_t push_desc;
  logic      head_valid;
  run_desc_t head;
  logic      pop;

  assign pready  = 1'b1;
  assign reg_hit = paddr[APB_AW-1:2] == ADDR_ORDER[APB_AW-1:2];
  assign prdata  = reg_hit ? APB_DW'(order_r) : '0;

  always_comb begin
    order_nxt = order_r;
    if (psel && penable && pwrite && reg_hit) begin
      order_nxt = pwdata[ORDER_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= '0;
    end else begin
      order_r <= order_nxt;
    end
  end

  sfm_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .order_sel  (order_r),
    .in_lbl     (in_lbl),
    .push_ready (push_ready),
    .push_valid (push_valid),
    .push_desc  (push_desc)
  );

  sfm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_desc  (push_desc),
    .pop_valid  (head_valid),
    .pop        (pop),
    .pop_desc   (head)
  );

  sfm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_sym    (out_sym)
  );

`ifndef NO_ASSERTIONS
  a_sync_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_sym.valid && out_sym.symbol_kind == KIND_SYNC) |-> !out_sym.last_of_run)
    else $error("sync symbol marked as end of run");

  a_train_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_sym.valid && out_sym.symbol_kind == KIND_TRAIN) |-> !out_sym.last_of_run)
    else $error("training symbol marked as end of run");

  a_accept_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (in_lbl.valid && in_lbl.ready) |-> ##2 out_sym.valid)
    else $error("accepted label produced no output symbol");
`endif

endmodule

// ----- design/sfm_front.sv -----
module sfm_front import sfm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [ORDER_W-1:0] order_sel,
  sfm_label_if.sink          in_lbl,
  input  logic               push_ready,
  output logic               push_valid,
  output run_desc_t          push_desc
);

  logic             train_done_r;
  logic             train_done_nxt;
  logic             in_interval_r;
  logic             in_interval_nxt;
  logic [POS_W-1:0] pos_r;
  logic [POS_W-1:0] pos_nxt;
  logic [GRP_W-1:0] grp_r;
  logic [GRP_W-1:0] grp_nxt;

  logic               accept;
  logic [POS_W-1:0]   pos_inc;
  logic [GRP_W-1:0]   grp_inc;
  logic               close;
  logic               pilot;
  logic [LABEL_W-1:0] idx;
  logic [31:0]        point;

  assign in_lbl.ready = push_ready;
  assign push_valid   = in_lbl.valid;
  assign accept       = in_lbl.valid & push_ready;

  always_comb begin
    pos_inc = in_interval_r ? pos_r + 1'b1 : POS_W'(1);
    grp_inc = in_interval_r ? grp_r + 1'b1 : GRP_W'(1);
    close   = pos_inc >= INTERVAL_SYMS[order_sel];
    pilot   = close || (grp_inc >= GRP_W'(PILOT_GAP));
    idx     = in_lbl.sym_label & LABEL_MASK[order_sel];
    point   = MAP_ROM[order_sel][idx];

    push_desc.train = (TRAIN_LEN != 0) && !train_done_r;
    push_desc.sync  = !in_interval_r;
    push_desc.pilot = pilot;
    push_desc.i_val = point[31:16];
    push_desc.q_val = point[15:0];

    train_done_nxt  = train_done_r;
    in_interval_nxt = in_interval_r;
    pos_nxt         = pos_r;
    grp_nxt         = grp_r;
    if (accept) begin
      train_done_nxt  = 1'b1;
      in_interval_nxt = !close;
      pos_nxt         = close ? '0 : pos_inc;
      grp_nxt         = pilot ? '0 : grp_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      train_done_r  <= 1'b0;
      in_interval_r <= 1'b0;
      pos_r         <= '0;
      grp_r         <= '0;
    end else begin
      train_done_r  <= train_done_nxt;
      in_interval_r <= in_interval_nxt;
      pos_r         <= pos_nxt;
      grp_r         <= grp_nxt;
    end
  end

endmodule

// ----- design/sfm_queue.sv -----
module sfm_queue import sfm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_valid,
  output logic      push_ready,
  input  run_desc_t push_desc,
  output logic      pop_valid,
  input  logic      pop,
  output run_desc_t pop_desc
);

  run_desc_t         mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r;
  logic [QCNT_W-1:0] count_nxt;
  logic              push;
  logic              take;

  assign push_ready = count_r != QCNT_W'(QUEUE_DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_desc   = mem_r[rd_ptr_r];
  assign push       = push_valid & push_ready;
  assign take       = pop & pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (take) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    unique case ({push, take})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule

// ----- design/sfm_back.sv -----
module sfm_back import sfm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      head_valid,
  input  run_desc_t head,
  output logic      pop,
  sfm_symbol_if.source out_sym
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_TRAIN = 3'd1;
  localparam logic [2:0] ST_SYNC  = 3'd2;
  localparam logic [2:0] ST_DATA  = 3'd3;
  localparam logic [2:0] ST_PILOT = 3'd4;

  logic [2:0]       st_r;
  logic [2:0]       st_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;

  logic signed [SAMP_W-1:0] out_i_r;
  logic signed [SAMP_W-1:0] out_q_r;
  logic [KIND_W-1:0]        out_kind_r;
  logic                     out_last_r;

  logic [2:0]        cur;
  logic              advance;
  logic              done;
  logic [31:0]       sym;
  logic [KIND_W-1:0] kind;

  always_comb begin
    priority if (st_r != ST_IDLE) cur = st_r;
    else if (head.train)          cur = ST_TRAIN;
    else if (head.sync)           cur = ST_SYNC;
    else                          cur = ST_DATA;

    advance = head_valid && (!out_valid_r || out_sym.ready);
    done    = 1'b0;
    st_nxt  = cur;
    cnt_nxt = cnt_r;
    sym     = {head.i_val, head.q_val};
    kind    = KIND_DATA;

    unique case (cur)
      ST_TRAIN: begin
        sym  = TRAIN_TAB[cnt_r[TRN_IW-1:0]];
        kind = KIND_TRAIN;
        if (cnt_r == CNT_W'(TRN_N - 1)) begin
          cnt_nxt = '0;
          st_nxt  = head.sync ? ST_SYNC : ST_DATA;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_SYNC: begin
        sym  = SYNC_TAB[cnt_r[SYN_IW-1:0]];
        kind = KIND_SYNC;
        if (cnt_r == CNT_W'(SYNC_LEN - 1)) begin
          cnt_nxt = '0;
          st_nxt  = ST_DATA;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_DATA: begin
        if (head.pilot) begin
          cnt_nxt = '0;
          st_nxt  = ST_PILOT;
        end else begin
          done = 1'b1;
        end
      end
      ST_PILOT: begin
        sym  = PILOT_TAB[cnt_r[PIL_IW-1:0]];
        kind = KIND_PILOT;
        if (cnt_r == CNT_W'(PILOT_LEN - 1)) begin
          done = 1'b1;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      default: begin
        done = 1'b1;
      end
    endcase

    if (done) begin
      st_nxt  = ST_IDLE;
      cnt_nxt = '0;
    end

    out_valid_nxt = advance || (out_valid_r && !out_sym.ready);
  end

  assign pop = advance && done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        st_r  <= st_nxt;
        cnt_r <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_i_r    <= sym[31:16];
      out_q_r    <= sym[15:0];
      out_kind_r <= kind;
      out_last_r <= done;
    end
  end

  assign out_sym.valid       = out_valid_r;
  assign out_sym.i_value     = out_i_r;
  assign out_sym.q_value     = out_q_r;
  assign out_sym.symbol_kind = out_kind_r;
  assign out_sym.last_of_run = out_last_r;

endmodule

// ----- tb/symbol_framer_mapper_tb.sv -----
module symbol_framer_mapper_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sfm_pkg::*;

  typedef enum logic [ORDER_W-1:0] {
    ORDER_4PT   = 2'd0,
    ORDER_16PT  = 2'd1,
    ORDER_64PT  = 2'd2,
    ORDER_256PT = 2'd3
  } order_t;

  typedef struct packed {
    logic signed [SAMP_W-1:0] i_val;
    logic signed [SAMP_W-1:0] q_val;
    logic [KIND_W-1:0]        kind;
    logic                     last;
  } symbol_t;

  localparam logic [31:0]              XS_SEED     = 32'h65a39c17;
  localparam logic signed [SAMP_W-1:0] SYNC_MAG    = 16'sd5793;
  localparam bit [63:0]                Q30_HALF_PI = 64'd1686629713;
  localparam bit [63:0]                Q30_ONE     = 64'd1 << 30;
  localparam int                       RING_R16 [2] = '{100, 285};
  localparam int                       RING_R   [8] = '{100, 280, 460, 640, 820, 1000, 1180, 1360};

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  sfm_label_if  lbl_if ();
  sfm_symbol_if sym_if ();

  symbol_framer_mapper dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_lbl  (lbl_if),
    .out_sym (sym_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  logic signed [SAMP_W-1:0] pt_i [4][256];
  logic signed [SAMP_W-1:0] pt_q [4][256];
  logic signed [SAMP_W-1:0] sw_i [SYNC_LEN];
  logic signed [SAMP_W-1:0] sw_q [SYNC_LEN];

  symbol_t     expected_symbols [$];
  order_t      cur_order;
  int unsigned trained;
  int unsigned data_pos;
  int unsigned grp_pos;
  bit          open_interval;
  bit          steady;
  int          mismatches;

  function automatic bit [63:0] int_sqrt(bit [63:0] v);
    bit [63:0] root;
    bit [63:0] probe;
    root  = '0;
    probe = 64'd1 << 62;
    while (probe > v) probe = probe >> 2;
    while (probe != 0) begin
      if (v >= root + probe) begin
        v    = v - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  // cosine when odd is clear, sine when set, q30 with truncation
  function automatic bit [63:0] taylor_q30(bit [63:0] ang, bit odd);
    bit [63:0] term;
    bit [63:0] den;
    longint    sum;
    int        k;
    term = odd ? ang : Q30_ONE;
    sum  = longint'(term);
    for (k = 1; k <= 10; k++) begin
      den  = 64'((2 * k - 1 + int'(odd)) * (2 * k + int'(odd)));
      term = (term * ang) >> 30;
      term = (term * ang) >> 30;
      term = term / den;
      if (k % 2 == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    if (sum > longint'(Q30_ONE)) sum = longint'(Q30_ONE);
    return $unsigned(sum);
  endfunction

  function automatic logic signed [SAMP_W-1:0] scale_q30(bit [63:0] amp, bit [63:0] mag);
    bit [63:0] prod;
    prod = amp * mag + (64'd1 << 46);
    return prod[62:47];
  endfunction

  function automatic void build_tables();
    bit [31:0]                x32;
    bit [63:0]                n_pts;
    bit [63:0]                energy;
    bit [63:0]                rad;
    bit [63:0]                a2;
    bit [63:0]                val;
    bit [63:0]                rem;
    bit [63:0]                amp;
    bit [63:0]                xx;
    bit [63:0]                mm;
    bit [63:0]                quad;
    bit [63:0]                ang;
    logic signed [SAMP_W-1:0] ci;
    logic signed [SAMP_W-1:0] si;
    int                       rings;
    int                       pop;
    int                       cnt;
    int                       gray;
    int                       o;
    int                       r;
    int                       p;
    int                       b;
    int                       s;
    x32 = XS_SEED;
    for (s = 0; s < SYNC_LEN; s++) begin
      x32     = x32 ^ (x32 << 13);
      x32     = x32 ^ (x32 >> 17);
      x32     = x32 ^ (x32 << 5);
      sw_i[s] = x32[0] ? SYNC_MAG : -SYNC_MAG;
      sw_q[s] = x32[1] ? SYNC_MAG : -SYNC_MAG;
    end
    for (o = 0; o < 4; o++) begin
      for (p = 0; p < 256; p++) begin
        pt_i[o][p] = '0;
        pt_q[o][p] = '0;
      end
      rings  = 1 << o;
      n_pts  = 64'd4 << (2 * o);
      energy = '0;
      cnt    = 0;
      for (r = 0; r < rings; r++) begin
        rad    = 64'((o == 1) ? RING_R16[r] : RING_R[r]);
        energy = energy + 64'(4 + 8 * r) * rad * rad;
      end
      for (r = 0; r < rings; r++) begin
        rad = 64'((o == 1) ? RING_R16[r] : RING_R[r]);
        a2  = rad * rad * n_pts;
        val = a2 / energy;
        rem = a2 % energy;
        for (b = 0; b < 60; b++) begin
          rem = rem << 1;
          val = (val << 1) | 64'(rem >= energy);
          if (rem >= energy) rem = rem - energy;
        end
        amp = int_sqrt(val);
        pop = 4 + 8 * r;
        for (p = 0; p < pop; p++) begin
          xx   = 64'(4 * (2 * p + 1));
          mm   = 64'(2 * pop);
          quad = xx / mm;
          ang  = Q30_HALF_PI * (xx % mm) / mm;
          ci   = scale_q30(amp, taylor_q30(ang, 1'b0));
          si   = scale_q30(amp, taylor_q30(ang, 1'b1));
          gray = (cnt ^ (cnt >> 1)) & 8'hff;
          case (quad[1:0])
            2'd0: begin
              pt_i[o][gray] = ci;
              pt_q[o][gray] = si;
            end
            2'd1: begin
              pt_i[o][gray] = -si;
              pt_q[o][gray] = ci;
            end
            2'd2: begin
              pt_i[o][gray] = -ci;
              pt_q[o][gray] = -si;
            end
            default: begin
              pt_i[o][gray] = si;
              pt_q[o][gray] = -ci;
            end
          endcase
          cnt++;
        end
      end
    end
  endfunction

  function automatic void queue_symbol(logic signed [SAMP_W-1:0] iv,
                                       logic signed [SAMP_W-1:0] qv,
                                       logic [KIND_W-1:0] kind);
    symbol_t sym;
    sym.i_val = iv;
    sym.q_val = qv;
    sym.kind  = kind;
    sym.last  = 1'b0;
    expected_symbols.push_back(sym);
  endfunction

  function automatic void predict_symbols(logic [LABEL_W-1:0] lbl);
    int unsigned        bps;
    int unsigned        per_interval;
    int unsigned        idx;
    int unsigned        k;
    logic [LABEL_W-1:0] code;
    bps          = 2 * (int'(cur_order) + 1);
    per_interval = (INTERVAL_BITS + bps - 1) / bps;
    while (trained < TRAIN_LEN) begin
      idx = (trained * 17 + 9) % SYNC_LEN;
      queue_symbol(-sw_q[idx], sw_i[idx], KIND_TRAIN);
      trained++;
    end
    if (!open_interval) begin
      for (k = 0; k < SYNC_LEN; k++) queue_symbol(sw_i[k], sw_q[k], KIND_SYNC);
      open_interval = 1'b1;
      data_pos      = 0;
      grp_pos       = 0;
    end
    code = lbl & LABEL_W'((1 << bps) - 1);
    queue_symbol(pt_i[cur_order][code], pt_q[cur_order][code], KIND_DATA);
    data_pos = (data_pos + 1) & 32'h3ff;
    grp_pos  = (grp_pos + 1) & 32'h1ff;
    if (data_pos >= per_interval || grp_pos >= PILOT_GAP) begin
      for (k = 0; k < PILOT_LEN; k++) begin
        idx = (11 + 13 * (k % 4)) % SYNC_LEN;
        queue_symbol(sw_i[idx], sw_q[idx], KIND_PILOT);
      end
      grp_pos = 0;
      if (data_pos >= per_interval) begin
        open_interval = 1'b0;
        data_pos      = 0;
      end
    end
    expected_symbols[expected_symbols.size() - 1].last = 1'b1;
  endfunction

  // entered just after a falling edge, returns just after one
  task automatic send_label(logic [LABEL_W-1:0] lbl);
    while (!steady && $urandom_range(99) < 13) begin
      lbl_if.valid     = 1'b0;
      lbl_if.sym_label = LABEL_W'($urandom);
      @(negedge clk);
    end
    lbl_if.valid     = 1'b1;
    lbl_if.sym_label = lbl;
    @(posedge clk);
    while (!lbl_if.ready) @(posedge clk);
    predict_symbols(lbl);
    @(negedge clk);
    lbl_if.valid = 1'b0;
  endtask

  task automatic write_order(order_t ord);
    while (expected_symbols.size() != 0) @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = ADDR_ORDER;
    pwdata  = APB_DW'(ord);
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    cur_order = ord;
    @(negedge clk);
    pwrite  = 1'b0;
    penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[ORDER_W-1:0] !== ord) begin
      $error("order_select: expected %0d, got %0d", ord, prdata[ORDER_W-1:0]);
      mismatches++;
    end
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // first transaction carries the training symbols, then label extremes per order
  task automatic test_labels_each_order();
    logic [LABEL_W-1:0] pattern [4];
    int                 o;
    int                 j;
    pattern = '{8'h00, 8'hff, 8'haa, 8'h55};
    for (o = 0; o < 4; o++) begin
      if (o != 0) write_order(order_t'(o));
      for (j = 0; j < 4; j++) send_label(pattern[j]);
    end
  endtask

  // order raised past the data count mid-interval, closing on a short group
  task automatic test_order_cut();
    write_order(ORDER_64PT);
    while (data_pos < 140) send_label(LABEL_W'($urandom));
    write_order(ORDER_256PT);
    send_label(LABEL_W'($urandom));
  endtask

  // whole interval back to back, last data symbol also ends a pilot group
  task automatic test_full_interval();
    steady = 1'b1;
    do send_label(LABEL_W'($urandom)); while (open_interval);
    steady = 1'b0;
  endtask

  task automatic test_random_orders();
    int sent;
    int chunk;
    sent = 0;
    write_order(ORDER_4PT);
    while (sent < 110) begin
      chunk = $urandom_range(30, 5);
      repeat (chunk) send_label(LABEL_W'($urandom));
      sent += chunk;
      write_order(order_t'($urandom_range(3, 0)));
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    sym_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      sym_if.ready = steady || ($urandom_range(99) >= 13);
    end
  end

  always @(posedge clk) begin
    symbol_t want;
    if (rst_n && sym_if.valid && sym_if.ready) begin
      if (expected_symbols.size() == 0) begin
        $error("symbol with no transaction pending: i %0d q %0d kind %0d",
               sym_if.i_value, sym_if.q_value, sym_if.symbol_kind);
        mismatches++;
      end else begin
        want = expected_symbols[0];
        expected_symbols.delete(0);
        if (sym_if.i_value !== want.i_val) begin
          $error("i_value: expected %0d, got %0d", want.i_val, sym_if.i_value);
          mismatches++;
        end
        if (sym_if.q_value !== want.q_val) begin
          $error("q_value: expected %0d, got %0d", want.q_val, sym_if.q_value);
          mismatches++;
        end
        if (sym_if.symbol_kind !== want.kind) begin
          $error("symbol_kind: expected %0d, got %0d", want.kind, sym_if.symbol_kind);
          mismatches++;
        end
        if (sym_if.last_of_run !== want.last) begin
          $error("last_of_run: expected %0d, got %0d", want.last, sym_if.last_of_run);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("symbol_framer_mapper: mismatch");
    $finish;
  end

  initial begin
    rst_n            = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    lbl_if.valid     = 1'b0;
    lbl_if.sym_label = '0;
    cur_order        = ORDER_4PT;
    trained          = 0;
    data_pos         = 0;
    grp_pos          = 0;
    open_interval    = 1'b0;
    steady           = 1'b0;
    mismatches       = 0;
    build_tables();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_labels_each_order();
    test_order_cut();
    test_full_interval();
    test_random_orders();

    while (expected_symbols.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("symbol_framer_mapper: match");
    end else begin
      $display("symbol_framer_mapper: mismatch");
    end
    $finish;
  end

endmodule
